// ===== rtl/core/scu_pkg.sv =====
// ----------------------------------------------------------------------------
// scu_pkg: shared definitions for the stack calculator unit
// Command and status codes, stream field widths, default sizes and the
// control bundle passed from the sequencer to the arithmetic unit.
// ----------------------------------------------------------------------------
package scu_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int DATA_WIDTH_DEF  = 32;

   localparam int CMD_W   = 3;
   localparam int VAL_W   = 32;
   localparam int DEPTH_W = 5;
   localparam int STAT_W  = 2;

   localparam int REQ_W      = 40;
   localparam int RSP_W      = 40;
   localparam int RSP_PAD_W  = RSP_W - VAL_W - DEPTH_W - STAT_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH = 3'd0,
      CMD_ADD  = 3'd1,
      CMD_SUB  = 3'd2,
      CMD_MUL  = 3'd3,
      CMD_DIV  = 3'd4,
      CMD_CMP  = 3'd5
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK       = 2'd0,
      STAT_UNDER    = 2'd1,
      STAT_OVER     = 2'd2,
      STAT_DIV_ZERO = 2'd3
   } stat_type;

   typedef struct packed {
      logic    start;
      cmd_type op;
   } alu_ctrl_type;

endpackage

// ===== rtl/core/scu_ram.sv =====
// ----------------------------------------------------------------------------
// scu_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module scu_ram #(
   parameter int WIDTH = scu_pkg::DATA_WIDTH_DEF,
   parameter int DEPTH = scu_pkg::STACK_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/scu_alu.sv =====
// ----------------------------------------------------------------------------
// scu_alu: iterative arithmetic unit
// One shared adder serves add, subtract and compare in one pass, shift-add
// multiply and restoring signed divide one bit per cycle.
// ----------------------------------------------------------------------------
module scu_alu #(
   parameter int DATA_WIDTH = scu_pkg::DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  scu_pkg::alu_ctrl_type ctrl,
   input  logic [DATA_WIDTH-1:0] opa,
   input  logic [DATA_WIDTH-1:0] opb,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] result
);

   localparam int STEP_W = $clog2(DATA_WIDTH);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_WIDTH - 1);

   typedef enum logic [2:0] {
      A_IDLE,
      A_ONE,
      A_MUL,
      A_ABSA,
      A_ABSB,
      A_DIV,
      A_FIX
   } alu_state_type;

   alu_state_type         state_ff;
   scu_pkg::cmd_type      op_ff;
   logic [DATA_WIDTH-1:0] opa_ff;
   logic [DATA_WIDTH-1:0] opb_ff;
   logic [DATA_WIDTH-1:0] acc_ff;
   logic [STEP_W-1:0]     step_ff;
   logic                  neg_ff;
   logic [DATA_WIDTH-1:0] res_ff;
   logic                  done_ff;

   logic [DATA_WIDTH:0]   add_x;
   logic [DATA_WIDTH:0]   add_y;
   logic                  add_c;
   logic [DATA_WIDTH:0]   sum;
   logic [DATA_WIDTH-1:0] cmp_res;
   logic                  qbit;

   always_comb begin
      add_x = '0;
      add_y = '0;
      add_c = 1'b0;
      case (state_ff)
         A_ONE: begin
            add_x = {opa_ff[DATA_WIDTH-1], opa_ff};
            if (op_ff == scu_pkg::CMD_ADD) begin
               add_y = {opb_ff[DATA_WIDTH-1], opb_ff};
            end else begin
               add_y = ~{opb_ff[DATA_WIDTH-1], opb_ff};
               add_c = 1'b1;
            end
         end
         A_MUL: begin
            add_x = {1'b0, acc_ff};
            add_y = opb_ff[0] ? {1'b0, opa_ff} : '0;
         end
         A_ABSA: begin
            add_y = ~{opa_ff[DATA_WIDTH-1], opa_ff};
            add_c = 1'b1;
         end
         A_ABSB: begin
            add_y = ~{opb_ff[DATA_WIDTH-1], opb_ff};
            add_c = 1'b1;
         end
         A_DIV: begin
            add_x = {acc_ff, opa_ff[DATA_WIDTH-1]};
            add_y = ~{1'b0, opb_ff};
            add_c = 1'b1;
         end
         A_FIX: begin
            add_y = ~{1'b0, opa_ff};
            add_c = 1'b1;
         end
         default: begin
            add_x = '0;
         end
      endcase
   end

   assign sum  = add_x + add_y + {{DATA_WIDTH{1'b0}}, add_c};
   assign qbit = ~sum[DATA_WIDTH];

   always_comb begin
      if (sum == '0) begin
         cmp_res = '0;
      end else if (sum[DATA_WIDTH]) begin
         cmp_res = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
      end else begin
         cmp_res = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            A_IDLE: begin
               if (ctrl.start) begin
                  op_ff   <= ctrl.op;
                  opa_ff  <= opa;
                  opb_ff  <= opb;
                  acc_ff  <= '0;
                  step_ff <= '0;
                  neg_ff  <= opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
                  case (ctrl.op)
                     scu_pkg::CMD_ADD, scu_pkg::CMD_SUB, scu_pkg::CMD_CMP: begin
                        state_ff <= A_ONE;
                     end
                     scu_pkg::CMD_MUL: begin
                        state_ff <= A_MUL;
                     end
                     scu_pkg::CMD_DIV: begin
                        state_ff <= A_ABSA;
                     end
                     default: begin
                        res_ff  <= '0;
                        done_ff <= 1'b1;
                     end
                  endcase
               end
            end
            A_ONE: begin
               res_ff   <= (op_ff == scu_pkg::CMD_CMP) ? cmp_res : sum[DATA_WIDTH-1:0];
               done_ff  <= 1'b1;
               state_ff <= A_IDLE;
            end
            A_MUL: begin
               acc_ff  <= sum[DATA_WIDTH-1:0];
               opa_ff  <= {opa_ff[DATA_WIDTH-2:0], 1'b0};
               opb_ff  <= {1'b0, opb_ff[DATA_WIDTH-1:1]};
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  res_ff   <= sum[DATA_WIDTH-1:0];
                  done_ff  <= 1'b1;
                  state_ff <= A_IDLE;
               end
            end
            A_ABSA: begin
               if (opa_ff[DATA_WIDTH-1]) begin
                  opa_ff <= sum[DATA_WIDTH-1:0];
               end
               state_ff <= A_ABSB;
            end
            A_ABSB: begin
               if (opb_ff[DATA_WIDTH-1]) begin
                  opb_ff <= sum[DATA_WIDTH-1:0];
               end
               state_ff <= A_DIV;
            end
            A_DIV: begin
               // shift the next dividend bit into the remainder, keep it if the trial fits
               if (qbit) begin
                  acc_ff <= sum[DATA_WIDTH-1:0];
               end else begin
                  acc_ff <= {acc_ff[DATA_WIDTH-2:0], opa_ff[DATA_WIDTH-1]};
               end
               opa_ff  <= {opa_ff[DATA_WIDTH-2:0], qbit};
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= A_FIX;
               end
            end
            A_FIX: begin
               res_ff   <= neg_ff ? sum[DATA_WIDTH-1:0] : opa_ff;
               done_ff  <= 1'b1;
               state_ff <= A_IDLE;
            end
            default: begin
               state_ff <= A_IDLE;
            end
         endcase
      end
   end

   assign done   = done_ff;
   assign result = res_ff;

   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> state_ff == A_IDLE)
      else $error("operation started while unit busy");

   a_done_pulse : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held for more than one cycle");

   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff == A_DIV |-> acc_ff < opb_ff)
      else $error("partial remainder not below divisor");

endmodule

// ===== rtl/core/stack_calculator_unit.sv =====
// ----------------------------------------------------------------------------
// stack_calculator_unit: stack-machine arithmetic unit
// Executes one push, add, subtract, multiply, divide or compare request on
// a LIFO of signed words and returns top, depth and status.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  req_    | in  | tdata[2:0] command, tdata[34:3] push_value
//  rsp_    | out | tdata[31:0] top_value, [36:32] depth, [38:37] status
//
//  Push, error and unused commands go from decode straight to the done state.
//  Add, subtract, compare take one pass of the shared adder; multiply and
//  divide run through it one bit per cycle, divide with sign fix-up steps.
//  One request is in flight at a time; req_tready is high only when idle.
//  A result waiting on rsp_tready holds the sequencer before its next result.
//  Reset clears the stack count; stack entries are not cleared.
// ----------------------------------------------------------------------------
module stack_calculator_unit #(
   parameter int STACK_DEPTH = scu_pkg::STACK_DEPTH_DEF,
   parameter int DATA_WIDTH  = scu_pkg::DATA_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [scu_pkg::REQ_W-1:0] req_tdata,  // command, push_value
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [scu_pkg::RSP_W-1:0] rsp_tdata   // top_value, depth, status
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0] TWO_CNT  = CNT_W'(2);
   localparam int VAL_W   = scu_pkg::VAL_W;
   localparam int CMD_W   = scu_pkg::CMD_W;
   localparam int DEPTH_W = scu_pkg::DEPTH_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_EXEC,
      S_DONE
   } state_type;

   state_type                    state_ff;
   scu_pkg::cmd_type             cmd_ff;
   logic [DATA_WIDTH-1:0]        pv_ff;
   logic [DATA_WIDTH-1:0]        top_ff;
   logic [CNT_W-1:0]             count_ff;
   scu_pkg::stat_type            stat_ff;
   logic                         rsp_valid_ff;
   logic [VAL_W-1:0]             rsp_top_ff;
   logic [DEPTH_W-1:0]           rsp_depth_ff;
   scu_pkg::stat_type            rsp_stat_ff;

   scu_pkg::stat_type            stat_in;
   logic                         fetch_in;
   logic [DATA_WIDTH+VAL_W-1:0]  pv_ext;
   logic [DATA_WIDTH+VAL_W-1:0]  top_ext;
   logic [CNT_W+DEPTH_W-1:0]     cnt_ext;
   logic [CNT_W-1:0]             cnt_m2;
   logic                         underflow;

   logic                         ram_wr_en;
   logic [ADDR_W-1:0]            ram_wr_addr;
   logic [DATA_WIDTH-1:0]        ram_wr_data;
   logic [DATA_WIDTH-1:0]        ram_rd_data;

   scu_pkg::alu_ctrl_type        alu_ctrl;
   logic                         alu_done;
   logic [DATA_WIDTH-1:0]        alu_res;

   assign pv_ext  = {{DATA_WIDTH{req_tdata[CMD_W+VAL_W-1]}}, req_tdata[CMD_W +: VAL_W]};
   assign top_ext = {{VAL_W{1'b0}}, top_ff};
   assign cnt_ext = {{DEPTH_W{1'b0}}, count_ff};
   assign cnt_m2  = count_ff - TWO_CNT;
   assign underflow = count_ff < TWO_CNT;

   always_comb begin
      stat_in  = scu_pkg::STAT_OK;
      fetch_in = 1'b0;
      case (cmd_ff)
         scu_pkg::CMD_PUSH: begin
            if (count_ff == FULL_CNT) begin
               stat_in = scu_pkg::STAT_OVER;
            end
         end
         scu_pkg::CMD_ADD, scu_pkg::CMD_SUB, scu_pkg::CMD_MUL, scu_pkg::CMD_CMP: begin
            if (underflow) begin
               stat_in = scu_pkg::STAT_UNDER;
            end else begin
               fetch_in = 1'b1;
            end
         end
         scu_pkg::CMD_DIV: begin
            if (underflow) begin
               stat_in = scu_pkg::STAT_UNDER;
            end else if (top_ff == '0) begin
               stat_in = scu_pkg::STAT_DIV_ZERO;
            end else begin
               fetch_in = 1'b1;
            end
         end
         default: begin
            stat_in = scu_pkg::STAT_OK;
         end
      endcase
   end

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = cnt_m2[ADDR_W-1:0];
      ram_wr_data = alu_res;
      if (state_ff == S_DECODE && cmd_ff == scu_pkg::CMD_PUSH && count_ff != FULL_CNT) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = count_ff[ADDR_W-1:0];
         ram_wr_data = pv_ff;
      end else if (state_ff == S_EXEC && alu_done) begin
         ram_wr_en = 1'b1;
      end
   end

   scu_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (cnt_m2[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign alu_ctrl.start = (state_ff == S_FETCH);
   assign alu_ctrl.op    = cmd_ff;

   scu_alu #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .opa    (ram_rd_data),
      .opb    (top_ff),
      .done   (alu_done),
      .result (alu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  cmd_ff   <= scu_pkg::cmd_type'(req_tdata[CMD_W-1:0]);
                  pv_ff    <= pv_ext[DATA_WIDTH-1:0];
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               stat_ff <= stat_in;
               if (cmd_ff == scu_pkg::CMD_PUSH && count_ff != FULL_CNT) begin
                  top_ff   <= pv_ff;
                  count_ff <= count_ff + 1'b1;
               end
               state_ff <= fetch_in ? S_FETCH : S_DONE;
            end
            S_FETCH: begin
               state_ff <= S_EXEC;
            end
            S_EXEC: begin
               if (alu_done) begin
                  top_ff   <= alu_res;
                  count_ff <= count_ff - 1'b1;
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               // hold until the output register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_top_ff   <= (count_ff != '0) ? top_ext[VAL_W-1:0] : '0;
                  rsp_depth_ff <= cnt_ext[DEPTH_W-1:0];
                  rsp_stat_ff  <= stat_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{scu_pkg::RSP_PAD_W{1'b0}}, rsp_stat_ff, rsp_depth_ff, rsp_top_ff};

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("stack count beyond depth");

   a_done_in_exec : assert property (@(posedge clock) disable iff (reset)
      alu_done |-> state_ff == S_EXEC)
      else $error("arithmetic result outside execute state");

   a_count_source : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(count_ff) |->
         $past(state_ff) == S_DECODE || $past(state_ff) == S_EXEC)
      else $error("stack count changed outside decode or execute");

endmodule

// ===== tb/stack_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_result_checker: response checker for the stack calculator unit
// Watches both stream channels. Every accepted request runs through a local
// stack machine whose outcome is queued. Every accepted response is compared
// field by field with the oldest queued outcome.
// ----------------------------------------------------------------------------
module stack_result_checker
   import scu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // command, push_value
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,   // top_value, depth, status
   output int               mismatches,
   output int               outstanding
);

   localparam int SLOTS = STACK_DEPTH_DEF;

   typedef struct packed {
      stat_type           status;
      logic [DEPTH_W-1:0] depth;
      logic [VAL_W-1:0]   top_value;
   } stack_outcome;

   logic [VAL_W-1:0]   words [SLOTS];
   logic [DEPTH_W-1:0] fill;
   stack_outcome       awaited_results [$];
   int                 error_total = 0;

   function automatic stack_outcome execute_instruction(logic [CMD_W-1:0] op,
                                                        logic [VAL_W-1:0] operand);
      logic [VAL_W-1:0] upper;
      logic [VAL_W-1:0] lower;
      logic [VAL_W-1:0] folded;
      longint           quotient;
      stack_outcome     outcome;
      outcome.status = STAT_OK;
      folded = '0;
      if (op == CMD_PUSH) begin
         if (fill >= SLOTS) begin
            outcome.status = STAT_OVER;
         end else begin
            words[fill] = operand;
            fill = fill + 1'b1;
         end
      end else if (op <= CMD_CMP) begin
         if (fill < 2) begin
            outcome.status = STAT_UNDER;
         end else begin
            upper = words[fill - 1];
            lower = words[fill - 2];
            case (op)
               CMD_ADD: folded = lower + upper;
               CMD_SUB: folded = lower - upper;
               CMD_MUL: folded = lower * upper;
               CMD_DIV: begin
                  if (upper == '0) begin
                     outcome.status = STAT_DIV_ZERO;
                  end else begin
                     quotient = longint'(signed'(lower)) / longint'(signed'(upper));
                     folded = quotient[VAL_W-1:0];
                  end
               end
               default: begin
                  if (signed'(upper) > signed'(lower))
                     folded = VAL_W'(1);
                  else if (upper == lower)
                     folded = '0;
                  else
                     folded = {VAL_W{1'b1}};
               end
            endcase
            if (outcome.status == STAT_OK) begin
               fill = fill - 1'b1;
               words[fill - 1] = folded;
            end
         end
      end
      outcome.top_value = (fill != '0) ? words[fill - 1] : '0;
      outcome.depth = fill;
      return outcome;
   endfunction

   always @(posedge clock) begin
      stack_outcome seen;
      stack_outcome want;
      if (reset) begin
         fill = '0;
         awaited_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen = stack_outcome'(rsp_tdata[VAL_W+DEPTH_W+STAT_W-1:0]);
            if (awaited_results.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               error_total++;
            end else begin
               want = awaited_results.pop_front();
               if (seen.top_value !== want.top_value) begin
                  $error("top_value: expected %h, got %h", want.top_value, seen.top_value);
                  error_total++;
               end
               if (seen.depth !== want.depth) begin
                  $error("depth: expected %0d, got %0d", want.depth, seen.depth);
                  error_total++;
               end
               if (seen.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, seen.status);
                  error_total++;
               end
            end
         end
         if (req_tvalid && req_tready)
            awaited_results.push_back(execute_instruction(req_tdata[CMD_W-1:0],
                                                          req_tdata[CMD_W+VAL_W-1:CMD_W]));
      end
      mismatches  <= error_total;
      outstanding <= awaited_results.size();
   end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the stack calculator unit
// Drives a short directed run of edge cases, then random instruction streams
// with bursts of idling on both channels, a long response hold-off and a
// drain pause. Checking is left to the response checker beside the block.
// ----------------------------------------------------------------------------
module tb;
   import scu_pkg::*;

   localparam int               REQUEST_COUNT = 450;
   localparam int               CYCLE_LIMIT   = 400_000;
   localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;
   localparam logic [VAL_W-1:0] WORD_MIN      = 32'h8000_0000;
   localparam logic [VAL_W-1:0] WORD_MAX      = 32'h7fff_ffff;

   logic             clock        = 1'b0;
   logic             reset        = 1'b1;
   logic             req_tvalid   = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata    = '0;
   logic             rsp_tvalid;
   logic             rsp_tready   = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             hold_request = 1'b0;
   logic             quiet        = 1'b0;
   int               mismatches;
   int               outstanding;
   int               cycles       = 0;
   int               depth_guess  = 0;
   int               burst_left   = 0;

   stack_calculator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   stack_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   task automatic issue(logic [CMD_W-1:0] op, logic [VAL_W-1:0] operand);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - CMD_W - VAL_W){1'b0}}, operand, op};
      do @(posedge clock); while (!req_tready);
   endtask

   // response side: random ready bursts, one long hold-off on request
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request <= 1'b0;
            rsp_tready   <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end
      end
   end

   initial begin
      int               counted;
      int               roll;
      logic [CMD_W-1:0] op;
      logic [CMD_W-1:0] arith;
      logic [VAL_W-1:0] operand;
      counted = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      issue(CMD_ADD, $urandom);
      issue(CMD_PUSH, WORD_MAX);
      issue(CMD_MUL, $urandom);
      issue(CMD_PUSH, VAL_W'(1));
      issue(CMD_ADD, $urandom);
      issue(CMD_PUSH, {VAL_W{1'b1}});
      issue(CMD_DIV, $urandom);
      issue(CMD_PUSH, '0);
      issue(CMD_DIV, $urandom);
      issue(CMD_CMP, $urandom);
      issue(CMD_PUSH, VAL_W'(1));
      issue(CMD_CMP, $urandom);
      issue(CMD_PUSH, -VAL_W'(5));
      issue(CMD_CMP, $urandom);
      issue(CMD_PUSH, VAL_W'(7));
      issue(CMD_SUB, $urandom);
      issue(CMD_PUSH, VAL_W'(3));
      issue(CMD_DIV, $urandom);
      issue(CMD_PUSH, 32'h1234_5678);
      issue(CMD_MUL, $urandom);
      issue(CMD_SPARE_LO, $urandom);
      issue(CMD_SPARE_HI, $urandom);
      depth_guess = 1;

      while (counted < REQUEST_COUNT) begin
         arith = CMD_W'($urandom_range(int'(CMD_ADD), int'(CMD_CMP)));
         roll  = $urandom_range(0, 99);
         if (burst_left > 0) begin
            op = CMD_PUSH;
            burst_left--;
         end else if (roll < 5) begin
            op = ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
         end else if (roll < 7) begin
            op = CMD_PUSH;
            burst_left = 18;
         end else if (depth_guess < 2) begin
            op = (roll < 90) ? CMD_PUSH : arith;
         end else if (depth_guess > 14) begin
            op = (roll < 25) ? CMD_PUSH : arith;
         end else begin
            op = (roll < 50) ? CMD_PUSH : arith;
         end
         case ($urandom_range(0, 9))
            0:       operand = '0;
            1:       operand = VAL_W'(1);
            2:       operand = {VAL_W{1'b1}};
            3:       operand = WORD_MIN;
            4:       operand = WORD_MAX;
            5, 6:    operand = VAL_W'($urandom_range(0, 200) - 100);
            default: operand = $urandom;
         endcase
         issue(op, operand);
         if (op == CMD_PUSH) begin
            if (depth_guess < STACK_DEPTH_DEF)
               depth_guess++;
         end else if (op <= CMD_CMP && depth_guess >= 2) begin
            depth_guess--;
         end
         counted++;
         if (counted == 100)
            hold_request <= 1'b1;
         if (counted == 250) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end
         if (counted == 400)
            quiet <= 1'b1;
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (80) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
